// ----- src/ptl_pkg.sv -----
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types and constants for the proportional text layout block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptl_pkg;

  // Fixed field widths
  localparam int CODE_W     = 8;
  localparam int POS_W      = 16;
  localparam int PAT_W      = 9;
  localparam int TABLE_SIZE = 256;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Special character codes
  localparam logic [CODE_W-1:0] CODE_END = 8'd0;
  localparam logic [CODE_W-1:0] CODE_NL  = 8'd10;

  // Input operations
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_WIDTH = 1'b1;

  // Alignment codes
  localparam logic [1:0] H_LEFT   = 2'd0;
  localparam logic [1:0] H_CENTER = 2'd1;
  localparam logic [1:0] H_RIGHT  = 2'd2;
  localparam logic [1:0] H_UNUSED = 2'd3;
  localparam logic [1:0] V_TOP    = 2'd0;
  localparam logic [1:0] V_MIDDLE = 2'd1;
  localparam logic [1:0] V_BOTTOM = 2'd2;
  localparam logic [1:0] V_UNUSED = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_CELL_WIDTH   = 3'd0;
  localparam logic [2:0] REG_CELL_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_PATTERN_BASE = 3'd2;
  localparam logic [2:0] REG_HORIZ_ALIGN  = 3'd3;
  localparam logic [2:0] REG_VERT_ALIGN   = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_CELL_WIDTH   = 8'd16;
  localparam logic [7:0] RST_CELL_HEIGHT  = 8'd16;
  localparam logic [7:0] RST_PATTERN_BASE = 8'd32;
  localparam logic [1:0] RST_HORIZ_ALIGN  = 2'd0;
  localparam logic [1:0] RST_VERT_ALIGN   = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SETUP,
    ST_RD_CHAR,
    ST_RD_WIDTH,
    ST_CALC
  } ptl_state_t;

  typedef struct packed {
    logic [7:0] cell_width;
    logic [7:0] cell_height;
    logic [7:0] pattern_base;
    logic [1:0] horiz_align;
    logic [1:0] vert_align;
  } ptl_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic take;   // input transaction accepted
    logic acc;    // add looked-up glyph width to current line
    logic setup;  // start of layout walk
    logic step;   // process current character of the walk
    logic clear;  // drop string state
  } ptl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_term;
    logic term_go;
    logic needs_acc;
    logic glyph;
    logic walk_end;
    logic out_free;
  } ptl_status_t;

endpackage

`default_nettype wire

// ----- src/ptl_ram.sv -----
// ----------------------------------------------------------------------------
// ptl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/ptl_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptl_ctrl
// Sequencer: character loading and the per-character layout walk.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ptl_pkg::ptl_status_t st,
  output ptl_pkg::ptl_cmd_t    cmd
);

  import ptl_pkg::*;

  ptl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.is_term) begin
            if (st.term_go) begin
              state_next = ST_SETUP;
            end else begin
              cmd.clear = 1'b1;
            end
          end else if (st.needs_acc) begin
            state_next = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_RD_CHAR;
      end
      ST_RD_CHAR: begin
        state_next = ST_RD_WIDTH;
      end
      ST_RD_WIDTH: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        // glyphs wait for a free output register
        if (!st.glyph || st.out_free) begin
          cmd.step = 1'b1;
          if (st.walk_end) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RD_CHAR;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/ptl_datapath.sv -----
// ----------------------------------------------------------------------------
// ptl_datapath
// Character store, width table, line widths and the position arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_datapath #(
  parameter int MAX_CHARS = 64,
  parameter int MAX_LINES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptl_pkg::ptl_cfg_t    cfg,
  input  ptl_pkg::ptl_cmd_t    cmd,
  output ptl_pkg::ptl_status_t st,
  input  logic                 op,
  input  logic [7:0]           char_code,
  input  logic [7:0]           glyph_width,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   pos_x,
  output logic signed [15:0]   pos_y,
  output logic signed [8:0]    pattern,
  output logic                 last,
  output logic                 overflowed
);

  import ptl_pkg::*;

  localparam int PB = $clog2(MAX_CHARS);
  localparam int CB = $clog2(MAX_CHARS + 1);
  localparam int LB = $clog2(MAX_LINES);
  localparam int NB = $clog2(MAX_LINES + 1);
  localparam int TB = $clog2(TABLE_SIZE);

  // String state
  logic [CB-1:0]     count;
  logic [LB-1:0]     line_index;
  logic              overflow;
  logic              have_glyph;
  logic [PB-1:0]     first_glyph;
  logic [PB-1:0]     last_glyph;
  logic [POS_W-1:0]  cur_width;
  logic [TABLE_SIZE-1:0] width_valid;
  logic              valid_q;

  // Walk state
  logic [PB-1:0]     pos;
  logic [LB-1:0]     ln;
  logic              need_init;
  logic [POS_W-1:0]  run;
  logic [POS_W-1:0]  dy;

  // Memory ports
  logic [7:0]        char_rdata;
  logic [7:0]        wt_rdata;
  logic [POS_W-1:0]  lw_rdata;
  logic [TB-1:0]     w_raddr;

  // Input decode
  logic is_load, is_term, is_nl, full, line_full;
  logic store_ch, store_nl, drop, wt_we;

  assign is_load   = (op == OP_LOAD);
  assign is_term   = is_load && (char_code == CODE_END);
  assign is_nl     = is_load && (char_code == CODE_NL);
  assign full      = (count == CB'(MAX_CHARS));
  assign line_full = (line_index == LB'(MAX_LINES - 1));
  assign store_ch  = cmd.take && is_load && !is_term && !is_nl && !full;
  assign store_nl  = cmd.take && is_nl && !full && !line_full;
  assign drop      = cmd.take && is_load && !is_term && (full || (is_nl && line_full));
  assign wt_we     = cmd.take && (op == OP_WIDTH);

  // Memories
  assign w_raddr = cmd.take ? char_code : char_rdata;

  ptl_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_char_ram (
    .clk   (clk),
    .we    (store_ch || store_nl),
    .waddr (count[PB-1:0]),
    .wdata (char_code),
    .raddr (pos),
    .rdata (char_rdata)
  );

  ptl_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_width_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (char_code),
    .wdata (glyph_width),
    .raddr (w_raddr),
    .rdata (wt_rdata)
  );

  ptl_ram #(.WIDTH(POS_W), .DEPTH(MAX_LINES)) u_line_ram (
    .clk   (clk),
    .we    (store_nl || (cmd.take && is_term)),
    .waddr (line_index),
    .wdata (cur_width),
    .raddr (ln),
    .rdata (lw_rdata)
  );

  // Effective glyph width: unwritten entries fall back to cell width
  logic [7:0] gw;
  assign gw = valid_q ? wt_rdata : cfg.cell_width;

  // Saturating line width sum
  logic [POS_W:0]   width_sum;
  logic [POS_W-1:0] cur_width_next;
  assign width_sum      = {1'b0, cur_width} + (POS_W + 1)'(gw);
  assign cur_width_next = width_sum[POS_W] ? '1 : width_sum[POS_W-1:0];

  // First vertical offset
  logic              right, center;
  logic [NB-1:0]     n_lines;
  logic [8+NB-1:0]   hn_full;
  logic [POS_W-1:0]  hn, hn_half, half_h, dy_init;
  logic [CB-1:0]     cnt_m1;

  assign right   = (cfg.horiz_align == H_RIGHT);
  assign center  = (cfg.horiz_align == H_CENTER);
  assign n_lines = NB'(line_index) + NB'(1);
  assign hn_full = cfg.cell_height * n_lines;
  assign hn      = POS_W'(hn_full);
  assign hn_half = {1'b0, hn[POS_W-1:1]};
  assign half_h  = POS_W'(cfg.cell_height[7:1]);
  assign cnt_m1  = count - CB'(1);

  always_comb begin
    if (right) begin
      unique case (cfg.vert_align)
        V_BOTTOM: dy_init = half_h;
        V_MIDDLE: dy_init = half_h - hn_half;
        default:  dy_init = half_h - hn;
      endcase
    end else begin
      unique case (cfg.vert_align)
        V_BOTTOM: dy_init = hn - half_h;
        V_MIDDLE: dy_init = hn_half - half_h;
        default:  dy_init = '0 - half_h;
      endcase
    end
  end

  // Horizontal step for one glyph
  logic [POS_W-1:0] run_base, run_eff, w16, dx_fwd, run_fwd, dx_rt, run_rt;
  logic [9:0]       diff, diff_adj;
  logic             glyph, walk_end, out_free, load_out;

  assign run_base = center ? ('0 - {1'b0, lw_rdata[POS_W-1:1]}) : '0;
  assign run_eff  = need_init ? (run_base + POS_W'(gw[7:1])) : run;
  // (cell_width - glyph width) / 2, truncated toward zero
  assign diff     = {2'b00, cfg.cell_width} - {2'b00, gw};
  assign diff_adj = diff + {9'b0, diff[9]};
  assign w16      = {{7{diff_adj[9]}}, diff_adj[9:1]};
  assign dx_fwd   = run_eff - w16;
  assign run_fwd  = dx_fwd + POS_W'(cfg.cell_width) - w16;
  assign dx_rt    = run_eff - (w16 + POS_W'(gw));
  assign run_rt   = dx_rt + w16;

  assign glyph    = (char_rdata != CODE_NL);
  assign walk_end = glyph && (pos == (right ? first_glyph : last_glyph));
  assign out_free = !out_valid || out_ready;
  assign load_out = cmd.step && glyph;

  // Status
  always_comb begin
    st           = '0;
    st.is_term   = is_term;
    st.term_go   = have_glyph && (cfg.horiz_align != H_UNUSED);
    st.needs_acc = is_load && !is_term && !is_nl && !full;
    st.glyph     = glyph;
    st.walk_end  = walk_end;
    st.out_free  = out_free;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      line_index  <= '0;
      overflow    <= 1'b0;
      have_glyph  <= 1'b0;
      cur_width   <= '0;
      width_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (wt_we) begin
        width_valid[char_code] <= 1'b1;
      end
      if (store_ch || store_nl) begin
        count <= count + CB'(1);
      end
      if (store_ch) begin
        have_glyph <= 1'b1;
      end
      if (store_nl) begin
        line_index <= line_index + LB'(1);
        cur_width  <= '0;
      end
      if (drop) begin
        overflow <= 1'b1;
      end
      if (cmd.acc) begin
        cur_width <= cur_width_next;
      end
      if (cmd.clear) begin
        count      <= '0;
        line_index <= '0;
        overflow   <= 1'b0;
        have_glyph <= 1'b0;
        cur_width  <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    valid_q <= width_valid[w_raddr];
    if (store_ch) begin
      last_glyph <= count[PB-1:0];
      if (!have_glyph) begin
        first_glyph <= count[PB-1:0];
      end
    end
    if (cmd.setup) begin
      pos       <= right ? cnt_m1[PB-1:0] : '0;
      ln        <= '0;
      need_init <= 1'b1;
      dy        <= dy_init;
    end
    if (cmd.step) begin
      pos <= right ? (pos - PB'(1)) : (pos + PB'(1));
      if (glyph) begin
        run       <= right ? run_rt : run_fwd;
        need_init <= 1'b0;
      end else begin
        // newline: next line, restart the run
        need_init <= 1'b1;
        ln        <= ln + LB'(1);
        dy        <= right ? (dy + POS_W'(cfg.cell_height))
                           : (dy - POS_W'(cfg.cell_height));
      end
    end
    if (load_out) begin
      pos_x      <= right ? dx_rt : dx_fwd;
      pos_y      <= dy;
      pattern    <= {1'b0, char_rdata} - {1'b0, cfg.pattern_base};
      last       <= walk_end;
      overflowed <= overflow;
    end
  end

endmodule

`default_nettype wire

// ----- src/proportional_text_layout.sv -----
// ----------------------------------------------------------------------------
// proportional_text_layout
// Loads a string and lays it out in a proportional font, one result per glyph.
// ----------------------------------------------------------------------------
// Loading: a width write or newline is handled in the idle state, a printable
// character adds a step (width table read, then line width add); a terminator
// that starts a walk adds setup. Layout: each walked character goes through
// character RAM read, width RAM read and position update; a glyph waits while the output is stalled.
// Reset: synchronous rst restores register defaults, marks all width entries
// unwritten and empties the string; no memory clearing pass is needed.
`default_nettype none

module proportional_text_layout #(
  parameter int MAX_CHARS = 64,
  parameter int MAX_LINES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ptl_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ptl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ptl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [7:0]                        char_code,
  input  logic [7:0]                        glyph_width,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                pos_x,
  output logic signed [15:0]                pos_y,
  output logic signed [8:0]                 pattern,
  output logic                              last,
  output logic                              overflowed
);

  import ptl_pkg::*;

  ptl_cfg_t    cfg;
  ptl_cmd_t    cmd;
  ptl_status_t st;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_width   <= RST_CELL_WIDTH;
      cfg.cell_height  <= RST_CELL_HEIGHT;
      cfg.pattern_base <= RST_PATTERN_BASE;
      cfg.horiz_align  <= RST_HORIZ_ALIGN;
      cfg.vert_align   <= RST_VERT_ALIGN;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CELL_WIDTH:   cfg.cell_width   <= pwdata[7:0];
        REG_CELL_HEIGHT:  cfg.cell_height  <= pwdata[7:0];
        REG_PATTERN_BASE: cfg.pattern_base <= pwdata[7:0];
        REG_HORIZ_ALIGN:  cfg.horiz_align  <= pwdata[1:0];
        REG_VERT_ALIGN:   cfg.vert_align   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_CELL_WIDTH:   prdata = APB_DATA_W'(cfg.cell_width);
      REG_CELL_HEIGHT:  prdata = APB_DATA_W'(cfg.cell_height);
      REG_PATTERN_BASE: prdata = APB_DATA_W'(cfg.pattern_base);
      REG_HORIZ_ALIGN:  prdata = APB_DATA_W'(cfg.horiz_align);
      REG_VERT_ALIGN:   prdata = APB_DATA_W'(cfg.vert_align);
      default:          prdata = '0;
    endcase
  end

  ptl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ptl_datapath #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_LINES (MAX_LINES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .st          (st),
    .op          (op),
    .char_code   (char_code),
    .glyph_width (glyph_width),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pattern     (pattern),
    .last        (last),
    .overflowed  (overflowed)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the proportional text layout block. Width table
// writes and character strings go in over a valid/ready channel; each laid-out
// glyph is compared against a local layout predictor. Directed strings cover
// every alignment, the register extremes and the newline edge cases. A pressure
// test overflows the line count while the output is held off.
// Random strings with random registers and width writes follow.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptl_pkg::*;

  localparam int MAX_CHARS    = 64;
  localparam int MAX_LINES    = 16;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [8:0]  pat;
    logic        last;
    logic        ovf;
  } glyph_t;

  // DUT signals
  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  op          = OP_LOAD;
  logic [7:0]            char_code   = '0;
  logic [7:0]            glyph_width = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic signed [15:0]    pos_x;
  logic signed [15:0]    pos_y;
  logic signed [8:0]     pattern;
  logic                  last;
  logic                  overflowed;

  // Run control
  int     err_count  = 0;
  int     items_sent = 0;
  int     cycle_cnt  = 0;
  int     tx_idle    = 34;
  int     rx_idle    = 34;
  int     hold_len   = 0;
  glyph_t glyph_q[$];

  // Predictor state
  bit [7:0] cfg_cw = RST_CELL_WIDTH;
  bit [7:0] cfg_ch = RST_CELL_HEIGHT;
  bit [7:0] cfg_pb = RST_PATTERN_BASE;
  bit [1:0] cfg_ha = RST_HORIZ_ALIGN;
  bit [1:0] cfg_va = RST_VERT_ALIGN;
  bit [7:0] wtab   [TABLE_SIZE];
  bit       wvalid [TABLE_SIZE];
  bit [7:0] cstore [MAX_CHARS];
  int       lw     [MAX_LINES];
  int       ccount = 0;
  int       lidx   = 0;
  bit       ovf    = 1'b0;
  glyph_t   held;
  bit       held_ok = 1'b0;

  proportional_text_layout #(
    .MAX_CHARS(MAX_CHARS),
    .MAX_LINES(MAX_LINES)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .char_code  (char_code),
    .glyph_width(glyph_width),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pattern    (pattern),
    .last       (last),
    .overflowed (overflowed)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int glyph_w(input bit [7:0] c);
    return wvalid[c] ? int'(wtab[c]) : int'(cfg_cw);
  endfunction

  // reads outside the stored string see the terminator code
  function automatic int char_at(input int p);
    if (p < 0 || p >= ccount || p >= MAX_CHARS) return int'(CODE_END);
    return int'(cstore[p]);
  endfunction

  function automatic int line_w(input int k);
    if (k < 0 || k >= MAX_LINES) return 0;
    return lw[k];
  endfunction

  // hold back one glyph so the final one can be flagged as last
  function automatic void add_glyph(input int x, input int y, input int c);
    glyph_t g;
    int     p;
    p = c - int'(cfg_pb);
    g.x    = x[15:0];
    g.y    = y[15:0];
    g.pat  = p[8:0];
    g.last = 1'b0;
    g.ovf  = ovf;
    if (held_ok) glyph_q.push_back(held);
    held    = g;
    held_ok = 1'b1;
  endfunction

  function automatic void layout_string();
    int h, cw, n, dy, dx, w, g, c, run, pos, ln;
    bit right, centre;
    if (ccount == 0 || cfg_ha == H_UNUSED) return;
    h      = int'(cfg_ch);
    cw     = int'(cfg_cw);
    n      = lidx + 1;
    right  = (cfg_ha == H_RIGHT);
    centre = (cfg_ha == H_CENTER);
    // first line offset; unused vertical code falls through to top
    if (!right) begin
      if (cfg_va == V_BOTTOM) dy = h * n - h / 2;
      else if (cfg_va == V_MIDDLE) dy = h * n / 2 - h / 2;
      else dy = -(h / 2);
    end else begin
      if (cfg_va == V_BOTTOM) dy = h / 2;
      else if (cfg_va == V_MIDDLE) dy = -(h * n / 2) + h / 2;
      else dy = -(h * n) + h / 2;
    end
    if (!right) begin
      // forward walk, centre shifts each line by half its width
      ln  = 0;
      pos = 0;
      run = (centre ? -line_w(ln) / 2 : 0) + glyph_w(8'(char_at(pos))) / 2;
      while (pos < ccount) begin
        c = char_at(pos);
        if (c == int'(CODE_NL)) begin
          ln++;
          pos++;
          run = (centre ? -line_w(ln) / 2 : 0) + glyph_w(8'(char_at(pos))) / 2;
          dy -= h;
          continue;
        end
        w   = (cw - glyph_w(8'(c))) / 2;
        dx  = run - w;
        run = dx + cw - w;
        add_glyph(dx, dy, c);
        pos++;
      end
    end else begin
      // backward walk from the last character
      pos = ccount - 1;
      run = glyph_w(8'(char_at(pos))) / 2;
      while (pos >= 0) begin
        c = char_at(pos);
        if (c == int'(CODE_NL)) begin
          pos--;
          run = glyph_w(8'(char_at(pos))) / 2;
          dy += h;
          continue;
        end
        g   = glyph_w(8'(c));
        w   = (cw - g) / 2;
        dx  = run - (w + g);
        run = dx + w;
        add_glyph(dx, dy, c);
        pos--;
      end
    end
    if (held_ok) begin
      held.last = 1'b1;
      glyph_q.push_back(held);
      held_ok = 1'b0;
    end
  endfunction

  function automatic void predict_item(input logic o, input logic [7:0] code,
                                       input logic [7:0] gw);
    int s;
    if (o == OP_WIDTH) begin
      wtab[code]   = gw;
      wvalid[code] = 1'b1;
      return;
    end
    if (code == CODE_END) begin
      layout_string();
      ccount = 0;
      lidx   = 0;
      ovf    = 1'b0;
      foreach (lw[k]) lw[k] = 0;
      return;
    end
    // full buffer drops the character
    if (ccount >= MAX_CHARS) begin
      ovf = 1'b1;
      return;
    end
    if (code == CODE_NL) begin
      // no room for another line: newline dropped
      if (lidx + 1 >= MAX_LINES) begin
        ovf = 1'b1;
        return;
      end
      cstore[ccount] = code;
      ccount++;
      lidx++;
      lw[lidx] = 0;
      return;
    end
    cstore[ccount] = code;
    ccount++;
    if (lidx < MAX_LINES) begin
      s = lw[lidx] + glyph_w(code);
      lw[lidx] = (s > 65535) ? 65535 : s;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    glyph_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {pos_x, pos_y, pattern, last, overflowed};
      if (glyph_q.size() == 0) begin
        report_mismatch($sformatf("unexpected glyph x=%0d y=%0d pat=%0d",
                                  pos_x, pos_y, pattern));
      end else begin
        want = glyph_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "glyph x=%0d/%0d y=%0d/%0d pat=%0d/%0d last=%b/%b ovf=%b/%b (got/exp)",
            $signed(got.x), $signed(want.x), $signed(got.y), $signed(want.y),
            $signed(got.pat), $signed(want.pat), got.last, want.last,
            got.ovf, want.ovf));
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random back-pressure, plus a long hold-off when requested
  initial begin : receiver
    int n;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // ---------------------------------------------------------------- drivers

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic o, input logic [7:0] code, input logic [7:0] gw);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    char_code   <= code;
    glyph_width <= gw;
    do @(posedge clk); while (!in_ready);
    predict_item(o, code, gw);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_char(input logic [7:0] code);
    send_item(OP_LOAD, code, 8'($urandom_range(0, 255)));
  endtask

  task automatic set_width(input logic [7:0] code, input logic [7:0] gw);
    send_item(OP_WIDTH, code, gw);
  endtask

  // wait out all expected glyphs plus the walk of a terminator with no output
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (glyph_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic set_config(input bit [7:0] cw, input bit [7:0] ch, input bit [7:0] pb,
                            input bit [1:0] ha, input bit [1:0] va);
    apb_write(REG_CELL_WIDTH, cw);
    apb_write(REG_CELL_HEIGHT, ch);
    apb_write(REG_PATTERN_BASE, pb);
    apb_write(REG_HORIZ_ALIGN, {6'd0, ha});
    apb_write(REG_VERT_ALIGN, {6'd0, va});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_cw = cw;
    cfg_ch = ch;
    cfg_pb = pb;
    cfg_ha = ha;
    cfg_va = va;
  endtask

  function automatic bit [7:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return 8'd1;
      1:       return 8'd255;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // mostly short strings, some long ones that overflow, some bare terminators
  task automatic send_random_string();
    int len, nl_pct;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 10);
    nl_pct = ($urandom_range(0, 3) == 0) ? 35 : 10;
    if ($urandom_range(0, 19) == 0) len = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8)
        set_width(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < nl_pct) load_char(CODE_NL);
      else load_char(8'($urandom_range(1, 255)));
    end
    load_char(CODE_END);
  endtask

  // ---------------------------------------------------------------- tests

  // reset registers: width writes, extremes of code, newline, empty string
  task automatic test_defaults();
    set_width("A", 8'd0);
    set_width(8'd255, 8'd255);
    load_char("A");
    load_char(8'd255);
    load_char(CODE_NL);
    load_char(" ");
    load_char(8'd9);      // below pattern base, negative pattern
    load_char(CODE_END);
    load_char(CODE_END);  // empty string
  endtask

  // every horizontal code and every vertical code but top, newlines at both ends
  task automatic test_alignment();
    wait_idle();
    set_config(8'd12, 8'd10, 8'd32, H_CENTER, V_MIDDLE);
    load_char("a");
    load_char("A");
    load_char(CODE_NL);
    load_char("c");
    load_char(CODE_NL);   // trailing newline reads past the end
    load_char(CODE_END);
    wait_idle();
    set_config(8'd12, 8'd10, 8'd32, H_RIGHT, V_BOTTOM);
    load_char(CODE_NL);   // leading newline reads before the start
    load_char("a");
    load_char(8'd255);
    load_char(CODE_NL);
    load_char(CODE_END);
    wait_idle();
    set_config(8'd12, 8'd10, 8'd32, H_UNUSED, V_BOTTOM);
    load_char("x");
    load_char(CODE_END);
    wait_idle();
    set_config(8'd12, 8'd10, 8'd32, H_LEFT, V_UNUSED);
    load_char("y");
    load_char(CODE_END);
  endtask

  task automatic test_extremes();
    wait_idle();
    set_config(8'd255, 8'd255, 8'd255, H_CENTER, V_BOTTOM);
    load_char("z");
    load_char(CODE_END);
    wait_idle();
    set_config(8'd1, 8'd1, 8'd0, H_RIGHT, V_MIDDLE);
    load_char("z");
    load_char(CODE_END);
  endtask

  // output held off while a line-overflowing string is sent
  task automatic test_backpressure();
    wait_idle();
    set_config(8'd16, 8'd16, 8'd32, H_LEFT, V_TOP);
    hold_len = 600;
    for (int i = 0; i < 72; i++) begin
      if (i % 3 == 2) load_char(CODE_NL);
      else load_char(8'($urandom_range(1, 255)));
    end
    load_char(CODE_END);
    for (int i = 0; i < 20; i++) load_char(8'($urandom_range(33, 126)));
    load_char(CODE_END);
  endtask

  task automatic test_random(input int phases, input int per_phase);
    int start;
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      set_config(pick_size(), pick_size(), 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 9) == 0) ? H_UNUSED : 2'($urandom_range(0, 2)),
                 2'($urandom_range(0, 3)));
      start = items_sent;
      while (items_sent - start < per_phase) send_random_string();
    end
  endtask

  // same traffic with both sides running flat out
  task automatic test_no_idle();
    tx_idle = 0;
    rx_idle = 0;
    test_random(1, 30);
    tx_idle = 34;
    rx_idle = 34;
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_defaults();
    test_alignment();
    test_extremes();
    test_backpressure();
    test_random(3, 40);
    test_no_idle();
    wait_idle();
    if (err_count == 0 && glyph_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
